/* src/mmh3_pkg.sv */
// ----------------------------------------------------------------------------
// mmh3_pkg
// Shared types and constants for the 32-bit MurmurHash3 core.
// ----------------------------------------------------------------------------
package mmh3_pkg;

  localparam logic [31:0] MixC1   = 32'hcc9e2d51;
  localparam logic [31:0] MixC2   = 32'h1b873593;
  localparam logic [31:0] FoldAdd = 32'he6546b64;
  localparam logic [31:0] FinM1   = 32'h85ebca6b;
  localparam logic [31:0] FinM2   = 32'hc2b2ae35;

  localparam logic [2:0]  BlockBytes = 3'd4;

  // How the back end treats one queued word
  typedef enum logic [1:0] {
    KIND_BLOCK = 2'd0,  // full block: scramble and fold
    KIND_TAIL  = 2'd1,  // one to three bytes: scramble, xor only
    KIND_NONE  = 2'd2   // empty last word: finalise only
  } mmh3_kind_e;

  typedef struct packed {
    logic [31:0] word;   // already masked for tails
    logic [2:0]  incr;   // bytes added to the length
    mmh3_kind_e  kind;
    logic        last;
  } mmh3_op_t;

endpackage

/* src/mmh3_in_if.sv */
// ----------------------------------------------------------------------------
// mmh3_in_if
// Input channel: one little-endian message word per item.
// ----------------------------------------------------------------------------
interface mmh3_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last_word;

  modport source (output valid, output data_word, output byte_count,
                  output last_word, input ready);
  modport sink   (input valid, input data_word, input byte_count,
                  input last_word, output ready);
endinterface

/* src/mmh3_out_if.sv */
// ----------------------------------------------------------------------------
// mmh3_out_if
// Output channel: one finished hash per item.
// ----------------------------------------------------------------------------
interface mmh3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

/* src/mmh3_front.sv */
// ----------------------------------------------------------------------------
// mmh3_front
// Accepts input items and classifies them into block, tail or empty ops.
// ----------------------------------------------------------------------------
module mmh3_front (
  mmh3_in_if.sink          in_i,
  input  logic             full_i,
  output logic             push_o,
  output mmh3_pkg::mmh3_op_t op_o
);
  import mmh3_pkg::*;

  logic [2:0] sat_cnt;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // counts above four saturate to a full block
  assign sat_cnt = (in_i.byte_count > BlockBytes) ? BlockBytes : in_i.byte_count;

  always_comb begin
    op_o.last = in_i.last_word;
    op_o.word = in_i.data_word;
    op_o.incr = BlockBytes;
    op_o.kind = KIND_BLOCK;
    if (in_i.last_word) begin
      op_o.incr = sat_cnt;
      unique case (sat_cnt)
        3'd0: begin
          op_o.kind = KIND_NONE;
        end
        3'd1: begin
          op_o.kind = KIND_TAIL;
          op_o.word = {24'd0, in_i.data_word[7:0]};
        end
        3'd2: begin
          op_o.kind = KIND_TAIL;
          op_o.word = {16'd0, in_i.data_word[15:0]};
        end
        3'd3: begin
          op_o.kind = KIND_TAIL;
          op_o.word = {8'd0, in_i.data_word[23:0]};
        end
        default: begin
          op_o.kind = KIND_BLOCK;
        end
      endcase
    end
  end

endmodule

/* src/mmh3_fifo.sv */
// ----------------------------------------------------------------------------
// mmh3_fifo
// Small op queue between front and back end.
// ----------------------------------------------------------------------------
module mmh3_fifo #(
  parameter int Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mmh3_pkg::mmh3_op_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output mmh3_pkg::mmh3_op_t data_o
);
  import mmh3_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  mmh3_op_t        mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + CW'(1))
    else $error("queue count did not follow a push");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");
`endif

endmodule

/* src/mmh3_back.sv */
// ----------------------------------------------------------------------------
// mmh3_back
// Hash engine: scrambles and folds queued words, finalises on the last one.
// ----------------------------------------------------------------------------
module mmh3_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               op_valid_i,
  input  mmh3_pkg::mmh3_op_t op_i,
  output logic               op_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        hash_o
);
  import mmh3_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL1 = 6'b000010,
    ST_MUL2 = 6'b000100,
    ST_MIX  = 6'b001000,
    ST_FIN1 = 6'b010000,
    ST_FIN2 = 6'b100000
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] hash_q, hash_d;
  logic [31:0] total_q, total_d;
  logic [31:0] k_q, k_d;
  mmh3_kind_e  kind_q, kind_d;
  logic        last_q, last_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_q;
  logic        out_load;

  logic [31:0] rot_k, mix_x, rot_h, fin_x, fin_y, fin_z, fin_res;

  // fixed rotates, xor-shifts and the second finalise multiply
  assign rot_k   = {k_q[16:0], k_q[31:17]};
  assign mix_x   = hash_q ^ k_q;
  assign rot_h   = {mix_x[18:0], mix_x[31:19]};
  assign fin_x   = (hash_q ^ total_q) ^ ((hash_q ^ total_q) >> 16);
  assign fin_y   = k_q ^ (k_q >> 13);
  assign fin_z   = fin_y * FinM2;
  assign fin_res = fin_z ^ (fin_z >> 16);

  assign out_valid_o = out_valid_q;
  assign hash_o      = out_q;

  always_comb begin
    state_d     = state_q;
    hash_d      = hash_q;
    total_d     = total_q;
    k_d         = k_q;
    kind_d      = kind_q;
    last_d      = last_q;
    op_pop_o    = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (op_valid_i) begin
          op_pop_o = 1'b1;
          k_d      = op_i.word;
          kind_d   = op_i.kind;
          last_d   = op_i.last;
          total_d  = total_q + {29'd0, op_i.incr};
          state_d  = (op_i.kind == KIND_NONE) ? ST_FIN1 : ST_MUL1;
        end
      end
      ST_MUL1: begin
        k_d     = k_q * MixC1;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        k_d     = rot_k * MixC2;
        state_d = ST_MIX;
      end
      ST_MIX: begin
        if (kind_q == KIND_BLOCK) begin
          hash_d = (rot_h << 2) + rot_h + FoldAdd;
        end else begin
          hash_d = mix_x;
        end
        state_d = last_q ? ST_FIN1 : ST_IDLE;
      end
      ST_FIN1: begin
        k_d     = fin_x * FinM1;
        state_d = ST_FIN2;
      end
      ST_FIN2: begin
        // wait here while the previous hash is still unclaimed
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          hash_d      = '0;
          total_d     = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hash_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    kind_q <= kind_d;
    last_q <= last_d;
    if (out_load) begin
      out_q <= fin_res;
    end
  end

`ifndef SYNTH
  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (hash_q == '0) && (total_q == '0))
    else $error("state not cleared after a hash was emitted");
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop_o |-> state_q == ST_IDLE)
    else $error("op dequeued while engine busy");
`endif

endmodule

/* src/murmur3_32_hash_core.sv */
// ----------------------------------------------------------------------------
// murmur3_32_hash_core
// MurmurHash3 x86_32 (seed zero) over a stream of little-endian words.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-----------------------------------------
//  in_i    | in  | valid / ready | data_word[31:0] byte_count[2:0] last_word
//  out_o   | out | valid / ready | hash_value[31:0]
//
//  A full block or tail word passes the engine states dequeue, two scramble
//  multiplies and fold; the last word adds the finalise states FIN1 and FIN2,
//  and an empty last word goes from dequeue straight to them. The sequencer
//  dequeues only when idle; each 32x32 multiply result is registered.
//  The front accepts up to FifoDepth items ahead of the engine; the output
//  register frees the engine as soon as the hash is loaded.
//  Reset clears the running hash, the byte total, the queue and out valid;
//  no clearing pass is needed.
// ----------------------------------------------------------------------------
module murmur3_32_hash_core #(
  parameter int FifoDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mmh3_in_if.sink     in_i,
  mmh3_out_if.source  out_o
);
  import mmh3_pkg::*;

  // front to queue
  logic     push;
  logic     full;
  mmh3_op_t push_op;

  // queue to engine
  logic     op_valid;
  logic     op_pop;
  mmh3_op_t head_op;

  // classify words: block, tail or empty last word
  mmh3_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .op_o   (push_op)
  );

  // decouples item acceptance from the multi-cycle engine
  mmh3_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_op),
    .full_o  (full),
    .pop_i   (op_pop),
    .valid_o (op_valid),
    .data_o  (head_op)
  );

  // scramble, fold and finalise; holds the output register
  mmh3_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_i        (head_op),
    .op_pop_o    (op_pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .hash_o      (out_o.hash_value)
  );

endmodule

/* tb/murmur3_32_hash_core_test.sv */
// ----------------------------------------------------------------------------
// murmur3_32_hash_core_test
// Self-checking bench for the MurmurHash3 x86_32 core: words are pushed in
// over the input channel, an in-bench hash predictor builds the expected
// digest per message, and every hash that leaves the core is checked in order.
// ----------------------------------------------------------------------------
module murmur3_32_hash_core_test;

  // Hash constants, kept local so the predictor does not lean on the DUT
  localparam logic [31:0] ScrambleMulA = 32'hcc9e2d51;
  localparam logic [31:0] ScrambleMulB = 32'h1b873593;
  localparam logic [31:0] FoldOffset   = 32'he6546b64;
  localparam logic [31:0] AvalMulA     = 32'h85ebca6b;
  localparam logic [31:0] AvalMulB     = 32'hc2b2ae35;

  localparam int HalfPeriod  = 5;
  localparam int ResetCycles = 12;
  localparam int DrainLimit  = 20000;  // cycles allowed for the tail to empty
  localparam int SettleTime  = 50;     // quiet cycles after the last hash

  logic clk = 1'b0;
  logic rst_n;

  mmh3_in_if  word_ch ();
  mmh3_out_if hash_ch ();

  murmur3_32_hash_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (word_ch),
    .out_o  (hash_ch)
  );

  always begin
    #HalfPeriod clk = 1'b1;
    #HalfPeriod clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: partial hash and byte length of the message in flight
  // --------------------------------------------------------------------------
  logic [31:0] acc_hash;
  logic [31:0] acc_len;
  logic [31:0] pending_hashes[$];  // digests still owed by the core, oldest first
  int unsigned fail_count;

  // Idle rates in percent, changed between random phases
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Block scramble: multiply, rotate left by 15, multiply
  function automatic logic [31:0] scramble_word(input logic [31:0] k);
    logic [31:0] t;
    t = k * ScrambleMulA;
    t = {t[16:0], t[31:17]};
    t = t * ScrambleMulB;
    return t;
  endfunction

  // Full-block fold: xor in, rotate left by 13, times five plus offset
  function automatic logic [31:0] fold_block(input logic [31:0] h,
                                             input logic [31:0] k);
    logic [31:0] t;
    t = h ^ scramble_word(k);
    t = {t[18:0], t[31:19]};
    return t * 32'd5 + FoldOffset;
  endfunction

  // Final avalanche over the hash already xored with the length
  function automatic logic [31:0] avalanche(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * AvalMulA;
    t = t ^ (t >> 13);
    t = t * AvalMulB;
    return t ^ (t >> 16);
  endfunction

  // Advance the predictor by one accepted word; a last word queues a digest
  task automatic absorb_word(input logic [31:0] word, input logic [2:0] cnt,
                             input logic last);
    logic [2:0]  nbytes;
    logic [31:0] tail;
    if (!last) begin
      // byte count is don't-care here: always a full block
      acc_hash = fold_block(acc_hash, word);
      acc_len  = acc_len + 32'd4;
    end else begin
      nbytes = (cnt > 3'd4) ? 3'd4 : cnt;  // 5..7 saturate to a full block
      case (nbytes)
        3'd4: acc_hash = fold_block(acc_hash, word);
        3'd3: tail = {8'h00, word[23:0]};
        3'd2: tail = {16'h0000, word[15:0]};
        3'd1: tail = {24'h000000, word[7:0]};
        default: tail = '0;
      endcase
      // tails skip the rotate / multiply-add step; bytes above are masked off
      if (nbytes != 3'd0 && nbytes != 3'd4) acc_hash = acc_hash ^ scramble_word(tail);
      acc_len = acc_len + 32'(nbytes);
      pending_hashes.push_back(avalanche(acc_hash ^ acc_len));
      acc_hash = '0;
      acc_len  = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: one item per call, with random idle cycles ahead of it.
  // Entered and left just after a rising edge; valid stays high across
  // back-to-back items so it never sees two updates in one step.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [31:0] word, input logic [2:0] cnt,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      word_ch.valid      <= 1'b0;
      word_ch.data_word  <= $urandom;   // junk payload while idle
      word_ch.byte_count <= 3'($urandom_range(7));
      word_ch.last_word  <= 1'($urandom_range(1));
      @(posedge clk);
    end
    word_ch.valid      <= 1'b1;
    word_ch.data_word  <= word;
    word_ch.byte_count <= cnt;
    word_ch.last_word  <= last;
    @(posedge clk);
    while (!word_ch.ready) @(posedge clk);
    absorb_word(word, cnt, last);
  endtask

  // Receiver: ready drops at random according to the current stall rate
  initial begin
    hash_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      hash_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Checker: every accepted hash against the oldest outstanding digest
  always @(posedge clk) begin : check_hash
    logic [31:0] want;
    if (rst_n && hash_ch.valid && hash_ch.ready) begin
      if (pending_hashes.size() == 0) begin
        $display("%0t: unexpected hash, expected none, got %08h",
                 $time, hash_ch.hash_value);
        fail_count++;
      end else begin
        want = pending_hashes.pop_front();
        if (hash_ch.hash_value !== want) begin
          $display("%0t: hash_value mismatch, expected %08h, got %08h",
                   $time, want, hash_ch.hash_value);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty message on its own, and an empty last word after full blocks
  task automatic test_empty_message();
    send_word(32'hffffffff, 3'd0, 1'b1);  // data must be ignored: hash is zero
    send_word(32'h12345678, 3'd7, 1'b0);  // byte count on non-last is ignored
    send_word(32'ha5a5a5a5, 3'd0, 1'b0);
    send_word(32'hffffffff, 3'd0, 1'b1);
  endtask

  // One to three tail bytes with the unused upper bytes all ones, then a tail after a block
  task automatic test_tail_masking();
    send_word(32'hffffffff, 3'd1, 1'b1);
    send_word(32'hffffffff, 3'd2, 1'b1);
    send_word(32'hffffffff, 3'd3, 1'b1);
    send_word(32'h01020304, 3'd4, 1'b0);
    send_word(32'hdeadbeef, 3'd2, 1'b1);
  endtask

  // Full last block, plus byte counts five to seven saturating to four
  task automatic test_full_block_saturation();
    send_word(32'h00000000, 3'd4, 1'b1);
    send_word(32'hffffffff, 3'd5, 1'b1);
    send_word(32'h80000001, 3'd6, 1'b1);
    send_word(32'h7ffffffe, 3'd7, 1'b1);
  endtask

  // Data word extremes inside one multi-word message
  task automatic test_word_extremes();
    send_word(32'h00000000, 3'd0, 1'b0);
    send_word(32'hffffffff, 3'd3, 1'b0);
    send_word(32'h80000000, 3'd1, 1'b0);
    send_word(32'h00000001, 3'd4, 1'b1);
  endtask

  // Random messages: mostly short, some long, last byte count over 0..7
  task automatic test_random_stream(input int unsigned n_items,
                                    input int unsigned idle_pct,
                                    input int unsigned stall_pct);
    int unsigned sent;
    int unsigned nwords;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      nwords = ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 5);
      repeat (nwords) send_word($urandom, 3'($urandom_range(7)), 1'b0);
      send_word($urandom, 3'($urandom_range(7)), 1'b1);
      sent += nwords + 1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run_tests
    int unsigned waited;
    acc_hash       = '0;
    acc_len        = '0;
    fail_count     = 0;
    send_idle_pct  = 10;
    recv_stall_pct = 57;
    rst_n              <= 1'b0;
    word_ch.valid      <= 1'b0;
    word_ch.data_word  <= '0;
    word_ch.byte_count <= '0;
    word_ch.last_word  <= 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_message();
    test_tail_masking();
    test_full_block_saturation();
    test_word_extremes();

    test_random_stream(400, 10, 57);
    test_random_stream(400, 57, 10);
    test_random_stream(400, 0, 0);

    word_ch.valid <= 1'b0;
    waited = 0;
    while (pending_hashes.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (pending_hashes.size() != 0) begin
      $display("%0t: %0d hashes never arrived, expected %08h first, got none",
               $time, pending_hashes.size(), pending_hashes[0]);
      fail_count++;
    end
    // watch for stray hashes a little longer
    repeat (SettleTime) @(posedge clk);

    if (fail_count == 0) begin
      $display("[murmur3_32_hash_core] OK");
    end else begin
      $display("[murmur3_32_hash_core] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #3000000;
    $display("[murmur3_32_hash_core] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
src/mmh3_pkg.sv
src/mmh3_in_if.sv
src/mmh3_out_if.sv
src/mmh3_front.sv
src/mmh3_fifo.sv
src/mmh3_back.sv
src/murmur3_32_hash_core.sv
tb/murmur3_32_hash_core_test.sv
